[rtl/erq_pkg.sv]
// ----------------------------------------------------------------------------
// erq_pkg
// Shared types and constants of the epoch retire queue.
// ----------------------------------------------------------------------------
package erq_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int EPOCH_BITS  = 32;
    localparam int HANDLE_BITS = 32;
    localparam int ACTION_W    = 8;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int QSIZE_W     = $clog2(RING_DEPTH + 1);
    localparam int CFG_QSIZE_W = 5;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;
    localparam int QSIZE_RESET = (RING_DEPTH < 16) ? RING_DEPTH : 16;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_REL  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // register indexes
    localparam logic REG_QUEUE_SIZE  = 1'b0;
    localparam logic REG_START_EPOCH = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [HANDLE_BITS-1:0] obj_handle;
        logic [ACTION_W-1:0]    release_action;
        logic [EPOCH_BITS-1:0]  oldest_epoch;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             kind;
        logic [EPOCH_BITS-1:0]  epoch_value;
        logic [HANDLE_BITS-1:0] released_handle;
        logic [ACTION_W-1:0]    released_action;
        logic                   is_full;
        logic                   clamped;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        logic                  clear;
        logic [QSIZE_W-1:0]    queue_size;
        logic [EPOCH_BITS-1:0] start_epoch;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic do_enq;
        logic eval_deq;
        logic emit_rel;
        logic emit_done;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic out_free;
        logic cnt_zero;
        logic cnt_one;
    } t_status;

endpackage

[rtl/erq_regs.sv]
// ----------------------------------------------------------------------------
// erq_regs
// APB register block: queue size and start epoch. A write empties the queue.
// ----------------------------------------------------------------------------
module erq_regs
    import erq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic                   r_clear;
    logic [QSIZE_W-1:0]     r_qsize;
    logic [QSIZE_W-1:0]     n_qsize;
    logic [EPOCH_BITS-1:0]  r_start;
    logic [CFG_QSIZE_W-1:0] wr_qsize;
    logic                   wr_en;
    logic                   reg_idx;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite;
    assign reg_idx  = paddr[2];
    assign wr_qsize = pwdata[CFG_QSIZE_W-1:0];

    // force the size into 1..RING_DEPTH
    always_comb begin
        if (wr_qsize == '0) begin
            n_qsize = QSIZE_W'(1);
        end else if (32'(wr_qsize) > 32'(RING_DEPTH)) begin
            n_qsize = QSIZE_W'(RING_DEPTH);
        end else begin
            n_qsize = QSIZE_W'(wr_qsize);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear <= 1'b0;
            r_qsize <= QSIZE_W'(QSIZE_RESET);
            r_start <= EPOCH_BITS'(1);
        end else begin
            r_clear <= wr_en;
            if (wr_en) begin
                unique case (reg_idx)
                    REG_QUEUE_SIZE:  r_qsize <= n_qsize;
                    REG_START_EPOCH: r_start <= EPOCH_BITS'(pwdata) | EPOCH_BITS'(1);
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_QUEUE_SIZE:  prdata = PDATA_W'(r_qsize);
            REG_START_EPOCH: prdata = PDATA_W'(r_start);
            default:         prdata = '0;
        endcase
    end

    // empty the queue in the cycle after the write, once the registers hold it
    assign o_cfg.clear       = r_clear;
    assign o_cfg.queue_size  = r_qsize;
    assign o_cfg.start_epoch = r_start;

endmodule

[rtl/erq_ctrl.sv]
// ----------------------------------------------------------------------------
// erq_ctrl
// Sequencer: take a word, execute enqueue or dequeue, walk releases, finish.
// ----------------------------------------------------------------------------
module erq_ctrl
    import erq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_REL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    if (i_status.op == OP_ENQ) begin
                        o_cmd.do_enq = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.eval_deq = 1'b1;
                        n_state        = i_status.cnt_zero ? ST_IDLE : ST_REL;
                    end
                end
            end
            ST_REL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_rel = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

[rtl/erq_dp.sv]
// ----------------------------------------------------------------------------
// erq_dp
// Datapath: retire ring, head/tail indexes and epochs, output word register.
// ----------------------------------------------------------------------------
module erq_dp
    import erq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  t_in_item  i_in_item,
    output t_out_item o_out_item,
    output logic      o_out_valid,
    input  logic      i_out_ready
);

    logic [HANDLE_BITS-1:0] mem_handle [RING_DEPTH];
    logic [ACTION_W-1:0]    mem_action [RING_DEPTH];
    logic [HANDLE_BITS-1:0] r_rd_handle;
    logic [ACTION_W-1:0]    r_rd_action;

    logic                   r_op;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [ACTION_W-1:0]    r_action;
    logic [EPOCH_BITS-1:0]  r_oldest;
    logic                   r_par_clamp;

    logic [IDX_W-1:0]       r_head_idx;
    logic [IDX_W-1:0]       r_tail_idx;
    logic [IDX_W-1:0]       n_head_idx;
    logic [IDX_W-1:0]       head_idx_inc;
    logic [IDX_W-1:0]       tail_idx_inc;
    logic [EPOCH_BITS-1:0]  r_head_ep;
    logic [EPOCH_BITS-1:0]  r_tail_ep;
    logic [QSIZE_W-1:0]     r_fill;
    logic [QSIZE_W-1:0]     r_rel_cnt;
    logic                   r_clamp;

    logic [EPOCH_BITS-1:0]  ep_delta;
    logic                   not_after;
    logic                   over;
    logic [QSIZE_W-1:0]     deq_cnt;
    logic                   deq_clamp;
    logic                   full;
    logic                   enq_wr;
    logic                   out_free;
    logic                   out_load;

    logic                   r_out_valid;
    t_out_item              r_out;
    t_out_item              n_out;

    // latch the word; round an even oldest epoch down to odd
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op        <= i_in_item.op;
            r_handle    <= i_in_item.obj_handle;
            r_action    <= i_in_item.release_action;
            r_oldest    <= i_in_item.oldest_epoch[0] ? i_in_item.oldest_epoch
                                                     : i_in_item.oldest_epoch - EPOCH_BITS'(1);
            r_par_clamp <= ~i_in_item.oldest_epoch[0];
        end
    end

    assign full   = (r_fill >= i_cfg.queue_size);
    assign enq_wr = i_cmd.do_enq & ~full;

    // span between head and tail is always twice the fill count
    assign ep_delta  = r_oldest - r_head_ep;
    assign not_after = (ep_delta == '0) || ep_delta[EPOCH_BITS-1];
    assign over      = ep_delta > EPOCH_BITS'({r_fill, 1'b0});

    always_comb begin
        if (not_after) begin
            deq_cnt = '0;
        end else if (over) begin
            deq_cnt = r_fill;
        end else begin
            deq_cnt = ep_delta[QSIZE_W:1];
        end
    end
    assign deq_clamp = r_par_clamp | (~not_after & over);

    // wrap at the configured size
    assign head_idx_inc = ((QSIZE_W'(r_head_idx) + QSIZE_W'(1)) == i_cfg.queue_size)
                          ? '0 : r_head_idx + IDX_W'(1);
    assign tail_idx_inc = ((QSIZE_W'(r_tail_idx) + QSIZE_W'(1)) == i_cfg.queue_size)
                          ? '0 : r_tail_idx + IDX_W'(1);

    always_comb begin
        if (i_cfg.clear) begin
            n_head_idx = '0;
        end else if (i_cmd.emit_rel) begin
            n_head_idx = head_idx_inc;
        end else begin
            n_head_idx = r_head_idx;
        end
    end

    // ring: write at tail, read ahead at the next head
    always_ff @(posedge i_clk) begin
        if (enq_wr) begin
            mem_handle[r_tail_idx] <= r_handle;
            mem_action[r_tail_idx] <= r_action;
        end
        r_rd_handle <= mem_handle[n_head_idx];
        r_rd_action <= mem_action[n_head_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_idx <= '0;
            r_tail_idx <= '0;
            r_head_ep  <= EPOCH_BITS'(1);
            r_tail_ep  <= EPOCH_BITS'(1);
            r_fill     <= '0;
        end else if (i_cfg.clear) begin
            r_head_idx <= '0;
            r_tail_idx <= '0;
            r_head_ep  <= i_cfg.start_epoch;
            r_tail_ep  <= i_cfg.start_epoch;
            r_fill     <= '0;
        end else if (enq_wr) begin
            r_tail_idx <= tail_idx_inc;
            r_tail_ep  <= r_tail_ep + EPOCH_BITS'(2);
            r_fill     <= r_fill + QSIZE_W'(1);
        end else if (i_cmd.emit_rel) begin
            r_head_idx <= head_idx_inc;
            r_head_ep  <= r_head_ep + EPOCH_BITS'(2);
            r_fill     <= r_fill - QSIZE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_deq) begin
            r_rel_cnt <= deq_cnt;
            r_clamp   <= deq_clamp;
        end else if (i_cmd.emit_rel) begin
            r_rel_cnt <= r_rel_cnt - QSIZE_W'(1);
        end
    end

    // output word register
    assign out_free = ~r_out_valid | i_out_ready;
    assign out_load = i_cmd.do_enq | i_cmd.emit_rel | i_cmd.emit_done
                    | (i_cmd.eval_deq & (deq_cnt == '0));

    always_comb begin
        n_out = '0;
        if (i_cmd.do_enq) begin
            n_out.kind        = KIND_ENQ;
            n_out.epoch_value = full ? '0 : r_tail_ep + EPOCH_BITS'(2);
            n_out.is_full     = full;
            n_out.last        = 1'b1;
        end else if (i_cmd.emit_rel) begin
            n_out.kind            = KIND_REL;
            n_out.epoch_value     = r_head_ep;
            n_out.released_handle = r_rd_handle;
            n_out.released_action = r_rd_action;
        end else if (i_cmd.emit_done) begin
            n_out.kind        = KIND_DONE;
            n_out.epoch_value = r_head_ep;
            n_out.clamped     = r_clamp;
            n_out.last        = 1'b1;
        end else begin
            // nothing to release: finish at once with the head unchanged
            n_out.kind        = KIND_DONE;
            n_out.epoch_value = r_head_ep;
            n_out.clamped     = deq_clamp;
            n_out.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.op       = r_op;
    assign o_status.out_free = out_free;
    assign o_status.cnt_zero = (deq_cnt == '0);
    assign o_status.cnt_one  = (r_rel_cnt == QSIZE_W'(1));

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= QSIZE_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_span_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail_ep - r_head_ep) == EPOCH_BITS'({r_fill, 1'b0}))
        else $error("epoch span disagrees with fill count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output word overwritten before taken");

    a_rel_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rel |-> (r_rel_cnt != '0) && (r_fill != '0))
        else $error("release from empty ring");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd))
        else $error("conflicting datapath commands");

endmodule

[rtl/epoch_retire_queue.sv]
// ----------------------------------------------------------------------------
// epoch_retire_queue
// Ring of retired objects tagged by odd epochs; releases on dequeue.
// ----------------------------------------------------------------------------
// Enqueue: answer word registered when the output is free; no new word until then.
// Dequeue releasing k > 0 entries: k release words, one a cycle while the output
// is free, then a done word; a dequeue that releases nothing gives only a done word.
// A stalled output holds the sequencer; the next word is taken once it goes idle.
// Reset (synchronous, active low): queue empty, size 16, start epoch 1.
// A register write empties the queue on the following cycle; no clearing pass.
module epoch_retire_queue
    import erq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    erq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    erq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    erq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

[tb/sv/epoch_retire_queue_tb.sv]
// ----------------------------------------------------------------------------
// epoch_retire_queue_tb
// Self-checking bench for the epoch retire queue. A predictor tracks the ring,
// head and tail epochs and register settings, and lists the result words each
// accepted input word must produce. A checker compares each output word with
// the oldest one due. Stimulus is a directed pass over corner cases, random
// traffic under several register settings, and a long output stall.
// ----------------------------------------------------------------------------
module epoch_retire_queue_tb;
    import erq_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    t_in_item           in_word;
    logic               out_valid;
    logic               out_ready;
    t_out_item          out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    epoch_retire_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic [HANDLE_BITS-1:0] handle_ring [RING_DEPTH];
    logic [ACTION_W-1:0]    action_ring [RING_DEPTH];
    int                     head_idx;
    int                     tail_idx;
    logic [EPOCH_BITS-1:0]  head_ep;
    logic [EPOCH_BITS-1:0]  tail_ep;
    int                     qsize;
    logic [EPOCH_BITS-1:0]  start_ep;

    t_out_item due_words [$];

    int words_in;
    int words_out;
    int releases_due;
    int refused_due;
    int clamps_due;
    int settings_used;
    int bad_count;
    int burst_left;

    // receiver stall control
    bit hold_req;
    int stall_left;
    int rx_mode;
    int rx_mode_left;
    int rx_phase;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("timeout: %0d result words still due", due_words.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic t_out_item make_word(logic [1:0] kind, logic [EPOCH_BITS-1:0] ep,
                                            logic [HANDLE_BITS-1:0] hnd,
                                            logic [ACTION_W-1:0] act,
                                            logic full, logic clamp, logic last);
        t_out_item w;
        w.kind            = kind;
        w.epoch_value     = ep;
        w.released_handle = hnd;
        w.released_action = act;
        w.is_full         = full;
        w.clamped         = clamp;
        w.last            = last;
        return w;
    endfunction

    function automatic void empty_ring();
        head_idx = 0;
        tail_idx = 0;
        head_ep  = start_ep;
        tail_ep  = start_ep;
    endfunction

    function automatic void apply_register(logic idx, logic [PDATA_W-1:0] val);
        if (idx == REG_QUEUE_SIZE) begin
            qsize = int'(val[CFG_QSIZE_W-1:0]);
            if (qsize == 0) qsize = 1;
            if (qsize > RING_DEPTH) qsize = RING_DEPTH;
        end else begin
            start_ep = val[EPOCH_BITS-1:0] | 1;
        end
        empty_ring();
    endfunction

    // List the result words one accepted input word causes, and advance the ring.
    function automatic void predict_results(t_in_item w);
        logic [EPOCH_BITS-1:0] span;
        logic [EPOCH_BITS-1:0] oldest;
        logic [EPOCH_BITS-1:0] ep_delta;
        logic                  clamp;
        span = tail_ep - head_ep;
        if (w.op == OP_ENQ) begin
            if (span[EPOCH_BITS-1:1] >= qsize) begin
                due_words.push_back(make_word(KIND_ENQ, '0, '0, '0, 1'b1, 1'b0, 1'b1));
                refused_due++;
            end else begin
                handle_ring[tail_idx] = w.obj_handle;
                action_ring[tail_idx] = w.release_action;
                tail_idx = (tail_idx + 1) % qsize;
                tail_ep  = tail_ep + 2;
                due_words.push_back(make_word(KIND_ENQ, tail_ep, '0, '0, 1'b0, 1'b0, 1'b1));
            end
        end else begin
            oldest = w.oldest_epoch;
            clamp  = 1'b0;
            // round an even epoch down to the odd one below
            if (!oldest[0]) begin
                oldest = oldest - 1;
                clamp  = 1'b1;
            end
            ep_delta = oldest - head_ep;
            if (ep_delta != 0 && !ep_delta[EPOCH_BITS-1]) begin
                if (ep_delta > span) begin
                    ep_delta = span;
                    clamp    = 1'b1;
                end
                while (ep_delta >= 2) begin
                    due_words.push_back(make_word(KIND_REL, head_ep, handle_ring[head_idx],
                                                  action_ring[head_idx], 1'b0, 1'b0, 1'b0));
                    releases_due++;
                    head_idx = (head_idx + 1) % qsize;
                    head_ep  = head_ep + 2;
                    ep_delta = ep_delta - 2;
                end
            end
            if (clamp) clamps_due++;
            due_words.push_back(make_word(KIND_DONE, head_ep, '0, '0, 1'b0, clamp, 1'b1));
        end
    endfunction

    task automatic report_bad(string what, t_out_item want, t_out_item got);
        bad_count++;
        if (bad_count <= 10)
            $display({"%s at %0t: want k=%0d ep=%h h=%h a=%h f=%b c=%b l=%b,",
                      " got k=%0d ep=%h h=%h a=%h f=%b c=%b l=%b"},
                     what, $time, want.kind, want.epoch_value, want.released_handle,
                     want.released_action, want.is_full, want.clamped, want.last,
                     got.kind, got.epoch_value, got.released_handle,
                     got.released_action, got.is_full, got.clamped, got.last);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            words_out++;
            if (due_words.size() == 0) begin
                report_bad("unexpected word", '0, out_word);
            end else begin
                want = due_words.pop_front();
                if (want.kind !== out_word.kind
                        || want.epoch_value !== out_word.epoch_value
                        || want.released_handle !== out_word.released_handle
                        || want.released_action !== out_word.released_action
                        || want.is_full !== out_word.is_full
                        || want.clamped !== out_word.clamped
                        || want.last !== out_word.last)
                    report_bad("field mismatch", want, out_word);
            end
        end
    end

    // Receiver: switch between stall patterns; honor a requested long hold-off.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = 250;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 160);
            end
            rx_mode_left--;
            case (rx_mode)
                0: out_ready = 1'b1;
                1: out_ready = 1'($urandom_range(0, 1));
                2: out_ready = ($urandom_range(0, 4) != 0);
                default: begin
                    rx_phase++;
                    out_ready = (rx_phase % 3 == 0);
                end
            endcase
        end
    end

    task automatic send_word(t_in_item w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_valid = 1'b1;
        in_word  = w;
        do @(posedge i_clk); while (!in_ready);
        words_in++;
        predict_results(w);
    endtask

    task automatic enq(logic [HANDLE_BITS-1:0] hnd, logic [ACTION_W-1:0] act);
        t_in_item w;
        w.op             = OP_ENQ;
        w.obj_handle     = hnd;
        w.release_action = act;
        w.oldest_epoch   = $urandom;
        send_word(w);
    endtask

    task automatic deq(logic [EPOCH_BITS-1:0] oldest);
        t_in_item w;
        w.op             = OP_DEQ;
        w.obj_handle     = $urandom;
        w.release_action = ACTION_W'($urandom_range(0, 255));
        w.oldest_epoch   = oldest;
        send_word(w);
    endtask

    // Drop valid and wait until every due word has come out.
    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [PDATA_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(idx, val);
        settings_used++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly epochs between head and just past tail; some even, behind head or wild.
    function automatic logic [EPOCH_BITS-1:0] pick_oldest();
        logic [EPOCH_BITS-1:0] held;
        int                    sel;
        held = (tail_ep - head_ep) >> 1;
        sel  = $urandom_range(0, 9);
        if (sel < 6) return head_ep + 2 * $urandom_range(0, held + 1);
        if (sel < 7) return head_ep + 2 * $urandom_range(0, held) + 1;
        if (sel < 8) return head_ep - 2 * $urandom_range(0, 4);
        return $urandom;
    endfunction

    task automatic run_random(int n_words, int enq_pct);
        t_in_item w;
        repeat (n_words) begin
            w.op             = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            w.obj_handle     = $urandom;
            w.release_action = ACTION_W'($urandom_range(0, 255));
            w.oldest_epoch   = pick_oldest();
            send_word(w);
        end
    endtask

    task automatic test_directed();
        deq(32'h0000_0001);       // oldest equals head
        deq(32'h0000_0000);       // even, wraps to behind head
        enq(32'h0000_0000, 8'h00);
        enq(32'hFFFF_FFFF, 8'hFF);
        enq(32'hA5A5_A5A5, 8'h5A);
        deq(32'h0000_0004);       // even oldest, release one
        deq(32'hFFFF_FFFF);       // far behind head
        deq(32'h0000_0101);       // beyond tail, clamp to tail
        settle();
        reg_write(REG_QUEUE_SIZE, 32'd2);
        enq(32'h1111_1111, 8'h11);
        enq(32'h2222_2222, 8'h22);
        enq(32'h3333_3333, 8'h33); // ring full
        deq(32'h0000_0005);
        enq(32'h4444_4444, 8'h44); // index wraps
        deq(32'hFFFF_FFFE);
        settle();
        reg_write(REG_QUEUE_SIZE, 32'd0);   // taken as one entry
        enq(32'h5555_5555, 8'h55);
        enq(32'h6666_6666, 8'h66);
        deq(32'h0000_0003);
        settle();
        reg_write(REG_QUEUE_SIZE, 32'd31);  // taken as the full ring
        reg_write(REG_START_EPOCH, 32'hFFFF_FFFE);
        enq(32'h7777_7777, 8'h77);
        enq(32'h8888_8888, 8'h88);
        enq(32'h9999_9999, 8'h99);
        deq(32'h0000_0003);       // release across the epoch wrap
        deq(32'h0000_0005);
        settle();
    endtask

    task automatic test_random_settings();
        logic [PDATA_W-1:0] sz;
        logic [PDATA_W-1:0] st;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin sz = 16; st = $urandom; end
                1: begin sz = 1;  st = 32'hFFFF_FFFF; end
                2: begin sz = 3;  st = 32'hFFFF_FFF0; end
                3: begin sz = 31; st = 32'hFFFF_FFE1; end
                4: begin sz = 0;  st = 32'h0000_0000; end
                5: begin sz = $urandom_range(2, 15); st = $urandom & ~32'h1; end
                default: begin sz = 16; st = 32'h0000_0001; end
            endcase
            settle();
            if (ph % 2 == 0) begin
                reg_write(REG_QUEUE_SIZE, sz);
                reg_write(REG_START_EPOCH, st);
            end else begin
                reg_write(REG_START_EPOCH, st);
                reg_write(REG_QUEUE_SIZE, sz);
            end
            run_random(45, (ph == 3) ? 70 : 58);
        end
        settle();
    endtask

    // Hold the output off while words keep coming, so the block stalls its input.
    task automatic test_backpressure();
        reg_write(REG_QUEUE_SIZE, 32'd16);
        @(posedge i_clk);
        hold_req   = 1'b1;
        burst_left = 1000;
        run_random(28, 100);
        run_random(14, 40);
        burst_left = 0;
        settle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_req     = 1'b0;
        stall_left   = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        rx_phase     = 0;
        burst_left   = 0;
        words_in     = 0;
        words_out    = 0;
        releases_due = 0;
        refused_due  = 0;
        clamps_due   = 0;
        settings_used = 0;
        bad_count    = 0;
        qsize        = QSIZE_RESET;
        start_ep     = 1;
        empty_ring();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_settings();
        test_backpressure();

        settle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d input words over %0d register writes; checked %0d result words",
                 words_in, settings_used, words_out);
        $display("including %0d releases, %0d refused enqueues, %0d clamped dequeues",
                 releases_due, refused_due, clamps_due);
        if (bad_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad result words", bad_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
